// ===== rtl/gpm_pkg.sv =====
// ----------------------------------------------------------------------------
// gpm_pkg
// Shared types, constants and helpers for the path matrix block.
// ----------------------------------------------------------------------------
package gpm_pkg;

    localparam int VERT_MAX = 16;
    localparam int ROW_W    = 16;
    localparam int IDX_W    = $clog2(VERT_MAX);
    localparam int CNT_W    = IDX_W + 1;
    localparam int VC_W     = 5;

    localparam logic [VC_W-1:0] VC_RESET         = VC_W'(VERT_MAX);
    localparam logic            REG_VERTEX_COUNT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_KRD,
        ST_KLD,
        ST_ROWS,
        ST_ORD,
        ST_OLD,
        ST_OWAIT
    } t_state;

    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] n;
    } t_start;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             we;
        logic [IDX_W-1:0] wr_addr;
        logic [ROW_W-1:0] wr_data;
    } t_ram_req;

    function automatic logic [CNT_W-1:0] sat_count(input logic [VC_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (int'(v) > VERT_MAX) begin
            r = CNT_W'(VERT_MAX);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] row_mask(input logic [CNT_W-1:0] n);
        logic [ROW_W-1:0] m;
        for (int j = 0; j < ROW_W; j++) begin
            m[j] = (j < int'(n));
        end
        return m;
    endfunction

endpackage

// ===== rtl/graph_path_matrix_connectivity.sv =====
// ----------------------------------------------------------------------------
// graph_path_matrix_connectivity
// Loads an adjacency matrix row by row and emits its boolean path matrix
// (transitive closure) row by row with a strongly-connected flag.
// ----------------------------------------------------------------------------
//  channel    | dir | payload
//  s_axis     | in  | tdata: row_index[3:0], row_bits[19:4]; tlast: last_row
//  m_axis     | out | tdata: out_row_index[3:0], path_row[19:4];
//             |     | tuser: strongly_connected; tlast: last_out
//  apb        | cfg | reg 0 at 0x0: vertex_count[4:0]
//
//  Load rows are taken one per cycle while the engine is idle. After the
//  last row the rows are copied into the reach RAM, then the closure runs
//  (one reach RAM row update per cycle, pausing at each pivot to fetch the
//  pivot row), then the output rows are read out, held while not taken.
//  No input is taken from the last row until the last result is taken.
//  Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module graph_path_matrix_connectivity
    import gpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // row_index[3:0], row_bits[19:4], zero pad
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // out_row_index[3:0], path_row[19:4], zero pad
    output logic        o_m_axis_tuser,   // strongly_connected
    output logic        o_m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [VC_W-1:0]  r_vertex_count;
    logic             idle;
    logic             in_acc;
    t_start           start;
    logic             adj_re;
    logic [IDX_W-1:0] adj_raddr;
    logic [ROW_W-1:0] adj_q;
    t_ram_req         reach;
    logic [ROW_W-1:0] reach_q;
    logic [IDX_W-1:0] o_idx;
    logic [ROW_W-1:0] o_row;

    assign pready = 1'b1;
    assign prdata = 32'(r_vertex_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VC_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_VERTEX_COUNT) begin
            r_vertex_count <= pwdata[VC_W-1:0];
        end
    end

    assign o_s_axis_tready = idle;
    assign in_acc          = i_s_axis_tvalid && idle;
    assign start.go        = in_acc && i_s_axis_tlast;
    assign start.n         = sat_count(r_vertex_count);

    gpm_ram #(.WIDTH(ROW_W), .DEPTH(VERT_MAX)) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (i_s_axis_tdata[IDX_W-1:0]),
        .i_wdata (i_s_axis_tdata[IDX_W+ROW_W-1:IDX_W]),
        .i_re    (adj_re),
        .i_raddr (adj_raddr),
        .o_rdata (adj_q)
    );

    gpm_ram #(.WIDTH(ROW_W), .DEPTH(VERT_MAX)) u_reach_ram (
        .i_clk   (i_clk),
        .i_we    (reach.we),
        .i_waddr (reach.wr_addr),
        .i_wdata (reach.wr_data),
        .i_re    (reach.rd_en),
        .i_raddr (reach.rd_addr),
        .o_rdata (reach_q)
    );

    gpm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_idle      (idle),
        .o_adj_re    (adj_re),
        .o_adj_raddr (adj_raddr),
        .i_adj_q     (adj_q),
        .o_reach     (reach),
        .i_reach_q   (reach_q),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_idx       (o_idx),
        .o_row       (o_row),
        .o_strong    (o_m_axis_tuser),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {4'b0, o_row, o_idx};

endmodule

// ===== rtl/gpm_ram.sv =====
// ----------------------------------------------------------------------------
// gpm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gpm_engine.sv =====
// ----------------------------------------------------------------------------
// gpm_engine
// Sequencer: copies adjacency rows into the reach RAM, runs the closure
// one row update per cycle bar pivot fetches, then streams the reach rows out.
// ----------------------------------------------------------------------------
module gpm_engine
    import gpm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_start           i_start,
    output logic             o_idle,
    output logic             o_adj_re,
    output logic [IDX_W-1:0] o_adj_raddr,
    input  logic [ROW_W-1:0] i_adj_q,
    output t_ram_req         o_reach,
    input  logic [ROW_W-1:0] i_reach_q,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [IDX_W-1:0] o_idx,
    output logic [ROW_W-1:0] o_row,
    output logic             o_strong,
    output logic             o_last
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_n, n_n;
    logic [ROW_W-1:0] r_mask, n_mask;
    logic [ROW_W-1:0] r_rowk, n_rowk;
    logic             r_strong, n_strong;
    logic             r_cp, n_cp;
    logic             r_wb, n_wb;
    logic [IDX_W-1:0] r_paddr, n_paddr;
    logic             r_ovalid, n_ovalid;
    logic [IDX_W-1:0] r_oidx, n_oidx;
    logic [ROW_W-1:0] r_orow, n_orow;
    logic             r_olast, n_olast;
    logic [ROW_W-1:0] upd;
    logic [CNT_W-1:0] n_last;
    logic [CNT_W-1:0] i_nxt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cp     <= 1'b0;
            r_wb     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cp     <= n_cp;
            r_wb     <= n_wb;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_k      <= n_k;
        r_n      <= n_n;
        r_mask   <= n_mask;
        r_rowk   <= n_rowk;
        r_strong <= n_strong;
        r_paddr  <= n_paddr;
        r_oidx   <= n_oidx;
        r_orow   <= n_orow;
        r_olast  <= n_olast;
    end

    assign n_last = r_n - CNT_W'(1);
    assign i_nxt  = r_i + CNT_W'(1);
    assign upd    = i_reach_q[r_k[IDX_W-1:0]] ? (i_reach_q | r_rowk) : i_reach_q;

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_k         = r_k;
        n_n         = r_n;
        n_mask      = r_mask;
        n_rowk      = r_rowk;
        n_strong    = r_strong;
        n_cp        = 1'b0;
        n_wb        = 1'b0;
        n_paddr     = r_paddr;
        n_ovalid    = r_ovalid;
        n_oidx      = r_oidx;
        n_orow      = r_orow;
        n_olast     = r_olast;
        o_adj_re    = 1'b0;
        o_adj_raddr = r_i[IDX_W-1:0];
        o_reach     = '0;

        // write-back of the request issued last cycle
        if (r_cp) begin
            o_reach.we      = 1'b1;
            o_reach.wr_addr = r_paddr;
            o_reach.wr_data = i_adj_q & r_mask;
        end else if (r_wb) begin
            o_reach.we      = 1'b1;
            o_reach.wr_addr = r_paddr;
            o_reach.wr_data = upd;
            if (r_k == n_last) begin
                n_strong = r_strong & (upd == r_mask);
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (i_start.go) begin
                    n_n     = i_start.n;
                    n_mask  = row_mask(i_start.n);
                    n_i     = '0;
                    n_state = ST_COPY;
                end
            end
            ST_COPY: begin
                if (r_i < r_n) begin
                    o_adj_re = 1'b1;
                    n_cp     = 1'b1;
                    n_paddr  = r_i[IDX_W-1:0];
                    n_i      = i_nxt;
                end else begin
                    n_k      = '0;
                    n_strong = 1'b1;
                    n_state  = ST_KRD;
                end
            end
            ST_KRD: begin
                o_reach.rd_en   = 1'b1;
                o_reach.rd_addr = r_k[IDX_W-1:0];
                n_state         = ST_KLD;
            end
            ST_KLD: begin
                n_rowk          = i_reach_q;
                o_reach.rd_en   = 1'b1;
                o_reach.rd_addr = '0;
                n_wb            = 1'b1;
                n_paddr         = '0;
                n_i             = CNT_W'(1);
                n_state         = ST_ROWS;
            end
            ST_ROWS: begin
                if (r_i < r_n) begin
                    o_reach.rd_en   = 1'b1;
                    o_reach.rd_addr = r_i[IDX_W-1:0];
                    n_wb            = 1'b1;
                    n_paddr         = r_i[IDX_W-1:0];
                    n_i             = i_nxt;
                end else if (r_k == n_last) begin
                    n_i     = '0;
                    n_state = ST_ORD;
                end else begin
                    n_k     = r_k + CNT_W'(1);
                    n_state = ST_KRD;
                end
            end
            ST_ORD: begin
                o_reach.rd_en   = 1'b1;
                o_reach.rd_addr = r_i[IDX_W-1:0];
                n_state         = ST_OLD;
            end
            ST_OLD: begin
                n_ovalid = 1'b1;
                n_oidx   = r_i[IDX_W-1:0];
                n_orow   = i_reach_q;
                n_olast  = (r_i == n_last);
                n_state  = ST_OWAIT;
            end
            ST_OWAIT: begin
                if (i_ready) begin
                    n_ovalid = 1'b0;
                    if (r_olast) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_i             = i_nxt;
                        o_reach.rd_en   = 1'b1;
                        o_reach.rd_addr = i_nxt[IDX_W-1:0];
                        n_state         = ST_OLD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_idle   = (r_state == ST_IDLE);
    assign o_valid  = r_ovalid;
    assign o_idx    = r_oidx;
    assign o_row    = r_orow;
    assign o_strong = r_strong;
    assign o_last   = r_olast;

endmodule
